[rtl/core/tmtd_pkg.sv]
// Package for the trimmed-mean threshold detector: sizing constants,
// field types, controller states and the controller/datapath command bundles.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmtd_pkg;

  // Window shape
  localparam int READINGS_PER_SAMPLE = 3;
  localparam int SAMPLES_PER_WINDOW  = 10;
  localparam int TRIM_EACH_END       = 2;
  localparam int KEEP_SAMPLES        = SAMPLES_PER_WINDOW - 2 * TRIM_EACH_END;
  localparam int KEEP_DIV            = (KEEP_SAMPLES > 0) ? KEEP_SAMPLES : 1;

  // Field widths
  localparam int DATA_W = 8;
  localparam logic [DATA_W-1:0] THRESHOLD_RESET = 8'd255;

  typedef logic [DATA_W-1:0] reading_t;
  typedef logic [DATA_W-1:0] sample_t;

  // Reading accumulator and sample divide (multiply by rounded-up reciprocal)
  localparam int SUM_W    = $clog2(255 * READINGS_PER_SAMPLE + 1);
  localparam int RCNT_W   = $clog2(READINGS_PER_SAMPLE + 1);
  localparam int R_SHIFT  = SUM_W + $clog2(READINGS_PER_SAMPLE);
  localparam int R_MULT   = (2 ** R_SHIFT + READINGS_PER_SAMPLE - 1) / READINGS_PER_SAMPLE;
  localparam int R_MULT_W = SUM_W + 1;
  localparam int RPROD_W  = SUM_W + R_MULT_W;

  // Window accumulator and mean divide
  localparam int MSUM_W   = $clog2(255 * KEEP_DIV + 1);
  localparam int M_SHIFT  = MSUM_W + $clog2(KEEP_DIV);
  localparam int M_MULT   = (2 ** M_SHIFT + KEEP_DIV - 1) / KEEP_DIV;
  localparam int M_MULT_W = MSUM_W + 1;
  localparam int MPROD_W  = MSUM_W + M_MULT_W;

  // Counters
  localparam int SCNT_W = $clog2(SAMPLES_PER_WINDOW + 1);
  localparam int STEP_W = $clog2(SAMPLES_PER_WINDOW);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SAMPLES_PER_WINDOW - 1);

  typedef logic [STEP_W-1:0] step_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SAMPLE,
    S_SORT,
    S_SUM,
    S_MEAN,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic  take;     // reading item accepted this cycle
    logic  sample;   // divide reading sum, push sample into the window
    logic  sort;     // one odd-even transposition round
    logic  sum;      // add window head, rotate window
    logic  mean;     // divide window sum
    logic  emit;     // load output register, update stop flag
    step_t step;     // round / position counter
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last_reading;  // current reading completes a sample
    logic window_full;   // pushed sample completes a window
    logic out_free;      // output register can take a result
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/core/tmtd_if.sv]
// Valid/ready channel interfaces for the reading input and the result output.
// Depends on tmtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tmtd_in_if;
  logic               valid;
  logic               ready;
  tmtd_pkg::reading_t reading;

  modport source (output valid, output reading, input ready);
  modport sink   (input valid, input reading, output ready);
endinterface

interface tmtd_out_if;
  logic              valid;
  logic              ready;
  tmtd_pkg::sample_t trimmed_mean;
  logic              stop_flag;

  modport source (output valid, output trimmed_mean, output stop_flag, input ready);
  modport sink   (input valid, input trimmed_mean, input stop_flag, output ready);
endinterface

`default_nettype wire

[rtl/core/tmtd_ctrl.sv]
// Sequencing state machine: reading intake, sample push, sort rounds,
// trimmed sum, mean divide and result hand-off. Depends on tmtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmtd_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  tmtd_pkg::dp_status_t   sts,
  output tmtd_pkg::ctrl_cmd_t    cmd
);
  import tmtd_pkg::*;

  state_t state_r, state_nxt;
  step_t  step_r, step_nxt;

  // State and step counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && sts.last_reading) state_nxt = S_SAMPLE;
      end
      S_SAMPLE: begin
        state_nxt = sts.window_full ? S_SORT : S_IDLE;
      end
      S_SORT: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_SUM;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_SUM: begin
        if (step_r == LAST_STEP) begin
          state_nxt = S_MEAN;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_MEAN: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.step   = step_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_SAMPLE: cmd.sample = 1'b1;
      S_SORT:   cmd.sort   = 1'b1;
      S_SUM:    cmd.sum    = 1'b1;
      S_MEAN:   cmd.mean   = 1'b1;
      S_EMIT:   cmd.emit   = sts.out_free;
      default:  in_ready   = 1'b0;
    endcase
  end

  // The reading that completes a sample is followed by the sample push
  a_sample_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && sts.last_reading) |=> state_r == S_SAMPLE)
    else $error("sample push did not follow last reading");

  // Sum phase ends after its last position
  a_sum_to_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SUM && step_r == LAST_STEP) |=> state_r == S_MEAN)
    else $error("sum phase overran");

  // A result waiting on a busy output register keeps the block in emit
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !sts.out_free) |=> state_r == S_EMIT)
    else $error("result dropped while output busy");

endmodule

`default_nettype wire

[rtl/core/tmtd_datapath.sv]
// Datapath: reading accumulator, sample window with transposition sort,
// trimmed sum, constant divides, threshold register and output register.
// Depends on tmtd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tmtd_datapath (
  input  wire                    clk,
  input  wire                    rst_n,
  input  tmtd_pkg::reading_t     reading,
  input  tmtd_pkg::ctrl_cmd_t    cmd,
  output tmtd_pkg::dp_status_t   sts,
  input  wire                    cfg_wr_en,
  input  tmtd_pkg::sample_t      cfg_wr_data,
  output logic                   out_valid,
  input  wire                    out_ready,
  output tmtd_pkg::sample_t      trimmed_mean,
  output logic                   stop_flag
);
  import tmtd_pkg::*;

  logic [SUM_W-1:0]   reading_sum_r;
  logic [RCNT_W-1:0]  reading_count_r;
  logic [SCNT_W-1:0]  sample_count_r;
  sample_t            store_r [SAMPLES_PER_WINDOW];
  sample_t            sort_nxt [SAMPLES_PER_WINDOW];
  logic [MSUM_W-1:0]  acc_r;
  sample_t            mean_r;
  sample_t            thr_r;
  logic               stop_r;
  logic               out_valid_r;
  sample_t            out_mean_r;
  logic               out_stop_r;

  logic [RPROD_W-1:0] sample_prod;
  sample_t            new_sample;
  logic [MPROD_W-1:0] mean_prod;
  logic               in_trim_window;
  logic               stop_nxt;

  // Status
  assign sts.last_reading = (reading_count_r == RCNT_W'(READINGS_PER_SAMPLE - 1));
  assign sts.window_full  = (sample_count_r == SCNT_W'(SAMPLES_PER_WINDOW - 1));
  assign sts.out_free     = !out_valid_r || out_ready;

  // Sum / READINGS_PER_SAMPLE by reciprocal multiply
  assign sample_prod = RPROD_W'(reading_sum_r) * RPROD_W'(R_MULT);
  assign new_sample  = sample_prod[R_SHIFT +: DATA_W];

  // Trimmed sum / KEEP_SAMPLES by reciprocal multiply
  assign mean_prod = MPROD_W'(acc_r) * MPROD_W'(M_MULT);

  // Positions that survive trimming
  assign in_trim_window = (int'(cmd.step) >= TRIM_EACH_END) &&
                          (int'(cmd.step) < TRIM_EACH_END + KEEP_SAMPLES);

  // One odd-even transposition round; the step LSB picks the pairing
  always_comb begin
    sort_nxt = store_r;
    for (int i = 0; i < SAMPLES_PER_WINDOW - 1; i++) begin
      if (((i & 1) == 1) == cmd.step[0]) begin
        if (store_r[i] > store_r[i+1]) begin
          sort_nxt[i]   = store_r[i+1];
          sort_nxt[i+1] = store_r[i];
        end
      end
    end
  end

  // Reading accumulator and sample counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reading_sum_r   <= '0;
      reading_count_r <= '0;
      sample_count_r  <= '0;
    end else begin
      if (cmd.take) begin
        reading_sum_r <= reading_sum_r + SUM_W'(reading);
        if (sts.last_reading) begin
          reading_count_r <= '0;
        end else begin
          reading_count_r <= reading_count_r + 1'b1;
        end
      end else if (cmd.sample) begin
        reading_sum_r <= '0;
        if (sts.window_full) begin
          sample_count_r <= '0;
        end else begin
          sample_count_r <= sample_count_r + 1'b1;
        end
      end
    end
  end

  // Sample window: push, sort round or rotate through the head
  always_ff @(posedge clk) begin
    if (cmd.sample) begin
      for (int i = 0; i < SAMPLES_PER_WINDOW - 1; i++) store_r[i] <= store_r[i+1];
      store_r[SAMPLES_PER_WINDOW-1] <= new_sample;
    end else if (cmd.sort) begin
      store_r <= sort_nxt;
    end else if (cmd.sum) begin
      for (int i = 0; i < SAMPLES_PER_WINDOW - 1; i++) store_r[i] <= store_r[i+1];
      store_r[SAMPLES_PER_WINDOW-1] <= store_r[0];
    end
  end

  // Trimmed-sum accumulator and mean
  always_ff @(posedge clk) begin
    if (cmd.sort) begin
      acc_r <= '0;
    end else if (cmd.sum && in_trim_window) begin
      acc_r <= acc_r + MSUM_W'(store_r[0]);
    end
    if (cmd.mean) begin
      mean_r <= (KEEP_SAMPLES > 0) ? mean_prod[M_SHIFT +: DATA_W] : '0;
    end
  end

  // Threshold register, sticky flag and output register
  assign stop_nxt = stop_r || (mean_r > thr_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THRESHOLD_RESET;
      stop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) thr_r <= cfg_wr_data;
      if (cmd.emit) begin
        stop_r      <= stop_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_mean_r <= mean_r;
      out_stop_r <= stop_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign trimmed_mean = out_mean_r;
  assign stop_flag    = out_stop_r;

  // Window counter wraps before reaching the window size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sample_count_r < SCNT_W'(SAMPLES_PER_WINDOW))
    else $error("sample count out of range");

  // Stop flag is sticky: only reset clears it
  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(stop_r))
    else $error("stop flag cleared without reset");

endmodule

`default_nettype wire

[rtl/core/trimmed_mean_threshold_detector.sv]
// Top level of the trimmed-mean threshold detector: controller, datapath
// and channel hookup. Depends on tmtd_pkg, tmtd_if, tmtd_ctrl, tmtd_datapath.
//
// Usage:
//   in_chan  : valid/ready channel of 8-bit readings; an item moves when
//              valid and ready are both high at a rising clock edge.
//   out_chan : valid/ready channel of results, one per window of 10 samples
//              (30 readings): trimmed_mean and the sticky stop_flag.
//   cfg_wr_en / cfg_wr_data : writes stop_threshold (reset 255) on any edge
//              with the enable high; used at the next window end.
// Flow: readings are taken while the controller is idle; every third reading is
//   followed by the sample divide, which holds intake. A window end then adds 10
//   sort rounds and 10 sum steps through the shared compare/add row, the mean
//   divide and the result hand-off, all with intake held.
// After a window's last reading the result passes sample, sort, sum, mean and emit.
// Reset (synchronous, rst_n low) clears the counters, the stop flag and the
//   output valid flag and loads the threshold with 255.
// A stalled receiver holds the result in the output register; the block keeps
//   taking readings and waits only if the next window result is ready first.
`timescale 1ns / 1ps
`default_nettype none

module trimmed_mean_threshold_detector (
  input  wire                 clk,
  input  wire                 rst_n,
  tmtd_in_if.sink             in_chan,
  tmtd_out_if.source          out_chan,
  input  wire                 cfg_wr_en,
  input  tmtd_pkg::sample_t   cfg_wr_data
);
  import tmtd_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;
  logic       out_valid;
  sample_t    trimmed_mean;
  logic       stop_flag;

  // Sequencer
  tmtd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Arithmetic and storage
  tmtd_datapath u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .reading      (in_chan.reading),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .out_valid    (out_valid),
    .out_ready    (out_chan.ready),
    .trimmed_mean (trimmed_mean),
    .stop_flag    (stop_flag)
  );

  // Channel hookup
  assign in_chan.ready         = in_ready;
  assign out_chan.valid        = out_valid;
  assign out_chan.trimmed_mean = trimmed_mean;
  assign out_chan.stop_flag    = stop_flag;

endmodule

`default_nettype wire

[tb/tmtd_checker.sv]
// Checker for the trimmed-mean threshold detector: watches the reading, result
// and threshold ports, predicts each window result and compares it on arrival.
// Depends on tmtd_pkg and tmtd_if.
`timescale 1ns / 1ps

module tmtd_checker (
  input  logic              clk,
  input  logic              rst_n,
  tmtd_in_if                in_mon,
  tmtd_out_if               out_mon,
  input  logic              cfg_wr_en,
  input  tmtd_pkg::sample_t cfg_wr_data,
  output int                mismatch_count,
  output int                windows_seen,
  output int                windows_pending
);
  import tmtd_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    sample_t mean;
    logic    stop;
  } window_result_t;

  // Predictor state
  sample_t        stop_threshold_q;
  int unsigned    reading_acc;
  int             readings_in_sample;
  sample_t        window_buf [SAMPLES_PER_WINDOW];
  int             samples_in_window;
  logic           stop_seen;
  window_result_t pending_results [$];
  window_result_t fresh;
  window_result_t due;

  // Sort a copy of the window, drop the ends, truncating mean of the rest
  function automatic sample_t trimmed_mean_of(input sample_t vals [SAMPLES_PER_WINDOW]);
    sample_t     ordered [SAMPLES_PER_WINDOW];
    sample_t     swap;
    int unsigned total;
    int          keep;
    ordered = vals;
    total   = 0;
    keep    = SAMPLES_PER_WINDOW - 2 * TRIM_EACH_END;
    if (keep <= 0) return '0;
    for (int i = 0; i < SAMPLES_PER_WINDOW - 1; i++) begin
      for (int j = 0; j < SAMPLES_PER_WINDOW - 1 - i; j++) begin
        if (ordered[j] > ordered[j+1]) begin
          swap         = ordered[j];
          ordered[j]   = ordered[j+1];
          ordered[j+1] = swap;
        end
      end
    end
    for (int k = TRIM_EACH_END; k < TRIM_EACH_END + keep; k++) total += ordered[k];
    return sample_t'(total / keep);
  endfunction

  task automatic log_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      stop_threshold_q   = THRESHOLD_RESET;
      reading_acc        = 0;
      readings_in_sample = 0;
      samples_in_window  = 0;
      stop_seen          = 1'b0;
      mismatch_count     = 0;
      windows_seen       = 0;
      pending_results.delete();
    end else begin
      if (cfg_wr_en) stop_threshold_q = cfg_wr_data;

      // Reading accepted: fold into the sample, close the window on the last one
      if (in_mon.valid && in_mon.ready) begin
        reading_acc += in_mon.reading;
        readings_in_sample++;
        if (readings_in_sample == READINGS_PER_SAMPLE) begin
          window_buf[samples_in_window] = sample_t'(reading_acc / READINGS_PER_SAMPLE);
          samples_in_window++;
          reading_acc        = 0;
          readings_in_sample = 0;
          if (samples_in_window == SAMPLES_PER_WINDOW) begin
            samples_in_window = 0;
            fresh.mean = trimmed_mean_of(window_buf);
            if (fresh.mean > stop_threshold_q) stop_seen = 1'b1;
            fresh.stop = stop_seen;
            pending_results.push_back(fresh);
          end
        end
      end

      // Result accepted: compare with the oldest prediction
      if (out_mon.valid && out_mon.ready) begin
        windows_seen++;
        if (pending_results.size() == 0) begin
          log_mismatch($sformatf("unexpected result mean=%0d stop=%0b",
                                 out_mon.trimmed_mean, out_mon.stop_flag));
        end else begin
          due = pending_results.pop_front();
          if (out_mon.trimmed_mean !== due.mean || out_mon.stop_flag !== due.stop) begin
            log_mismatch($sformatf("mean exp=%0d got=%0d, stop exp=%0b got=%0b",
                                   due.mean, out_mon.trimmed_mean,
                                   due.stop, out_mon.stop_flag));
          end
        end
      end
    end
    windows_pending = pending_results.size();
  end

endmodule

[tb/tb_trimmed_mean_threshold_detector.sv]
// Testbench top for the trimmed-mean threshold detector: clock, reset, reading
// stimulus, result-side back-pressure, threshold writes and the verdict.
// Depends on tmtd_pkg, tmtd_if, trimmed_mean_threshold_detector and tmtd_checker.
`timescale 1ns / 1ps

module tb_trimmed_mean_threshold_detector;
  import tmtd_pkg::*;

  localparam int CYCLE_LIMIT         = 200000;
  localparam int READINGS_PER_WINDOW = READINGS_PER_SAMPLE * SAMPLES_PER_WINDOW;
  localparam int CHUNK_READINGS      = 125;
  localparam int CHUNKS_PER_PHASE    = 3;
  localparam int PHASES              = 3;
  localparam int HOLD_OFF_CYCLES     = 500;
  localparam int SETTLE_CYCLES       = 40;

  typedef enum int {MIX_UNIFORM, MIX_FLAT, MIX_CLUSTER} window_mix_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    cfg_wr_en;
  sample_t cfg_wr_data;

  tmtd_in_if  in_chan ();
  tmtd_out_if out_chan ();

  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  int          readings_sent = 0;
  int          cycle_count = 0;
  window_mix_t window_mix = MIX_UNIFORM;
  int          window_level = 0;
  int          window_spread = 0;
  int          mismatch_count;
  int          windows_seen;
  int          windows_pending;

  // One window of corner readings: full scale, zero, truncation edges, ends to trim
  reading_t corner_readings [READINGS_PER_WINDOW] = '{
    8'd255, 8'd255, 8'd255,  8'd0,   8'd0,   8'd0,
    8'd255, 8'd255, 8'd254,  8'd0,   8'd0,   8'd1,
    8'd1,   8'd1,   8'd0,    8'd100, 8'd101, 8'd101,
    8'd200, 8'd200, 8'd200,  8'd50,  8'd50,  8'd51,
    8'd255, 8'd0,   8'd0,    8'd0,   8'd255, 8'd255
  };

  trimmed_mean_threshold_detector i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  tmtd_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_chan),
    .out_mon         (out_chan),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .mismatch_count  (mismatch_count),
    .windows_seen    (windows_seen),
    .windows_pending (windows_pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stalls, plus a long hold-off when one is requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left      <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served    <= hold_requests;
      hold_left      <= HOLD_OFF_CYCLES;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d windows still owed", cycle_count, windows_pending);
    $display("status: fail");
    $finish;
  end

  task automatic send_reading(input reading_t value);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.reading <= value;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    readings_sent++;
  endtask

  // Readings follow a per-window mix so window means spread over the full range
  task automatic send_random_reading();
    int pick;
    int value;
    if (readings_sent % READINGS_PER_WINDOW == 0) begin
      pick = $urandom_range(9);
      window_level  = $urandom_range(255);
      window_spread = $urandom_range(40);
      case (pick)
        0: begin
          window_mix   = MIX_FLAT;
          window_level = 0;
        end
        1: begin
          window_mix   = MIX_FLAT;
          window_level = 255;
        end
        2:       window_mix = MIX_FLAT;
        3, 4:    window_mix = MIX_UNIFORM;
        default: window_mix = MIX_CLUSTER;
      endcase
    end
    case (window_mix)
      MIX_UNIFORM: value = $urandom_range(255);
      MIX_FLAT:    value = window_level;
      default: begin
        value = window_level + int'($urandom_range(2 * window_spread)) - window_spread;
        if (value < 0) value = 0;
        if (value > 255) value = 255;
      end
    endcase
    send_reading(reading_t'(value));
  endtask

  // Stop offering, let every owed result drain, then let the block go quiet.
  // One edge first so the checker has booked the item accepted last.
  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (windows_pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input sample_t value);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Threshold per chunk: never trips first, then near the top, then both extremes and a random value
  function automatic sample_t chunk_threshold(input int phase, input int chunk);
    if (phase == 0) return THRESHOLD_RESET;
    if (phase == 1) return (chunk == 1) ? sample_t'(200) : sample_t'($urandom_range(128, 254));
    if (chunk == 0) return '0;
    if (chunk == 1) return sample_t'($urandom_range(255));
    return sample_t'(255);
  endfunction

  initial begin
    in_chan.valid   = 1'b0;
    in_chan.reading = '0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner window under the reset threshold, rewritten halfway through
    tx_idle_pct = 33;
    rx_idle_pct = 51;
    for (int i = 0; i < READINGS_PER_WINDOW; i++) begin
      if (i == READINGS_PER_WINDOW / 2) begin
        drain_results();
        write_threshold(THRESHOLD_RESET);
      end
      send_reading(corner_readings[i]);
    end

    // Random phases; chunks end mid-window so threshold writes land mid-window too
    for (int phase = 0; phase < PHASES; phase++) begin
      tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 51 : 0;
      rx_idle_pct = (phase == 0) ? 51 : (phase == 1) ? 33 : 0;
      for (int chunk = 0; chunk < CHUNKS_PER_PHASE; chunk++) begin
        drain_results();
        write_threshold(chunk_threshold(phase, chunk));
        if (phase == 0 && chunk == 1) hold_requests++;
        repeat (CHUNK_READINGS) send_random_reading();
      end
    end

    drain_results();
    $display("Covered %0d readings and %0d window results, thresholds from 0 to 255,",
             readings_sent, windows_seen);
    $display("with a long result stall, drain pauses and three idle mixes.");
    if (mismatch_count == 0 && windows_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
